### design/lzpid_pkg.sv
package lzpid_pkg;

    // History window; the ring address width follows from it.
    localparam int WINDOW_BYTES = 8192;
    localparam int RING_AW      = $clog2(WINDOW_BYTES);

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int MODE_W    = 3;
    localparam int OFS_W     = 14;
    localparam int COUNT_W   = 24;
    localparam int NUM_MODES = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [MODE_W-1:0]  MODE_LITERAL = '0;
    localparam logic [LEN_W-1:0]   LEN_ZERO     = '0;
    localparam logic [OFS_W-1:0]   OFS_RESET    = {OFS_W{1'b1}};

    typedef logic [OFS_W-1:0] offset_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

### design/lzpid_ram.sv
module lzpid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/lz_predictive_image_decompressor_unit.sv
// Byte-serial LZ/RLE decompressor. Each input word is one compressed source byte;
// each output word is one decompressed byte or a bare end marker (has_byte low).
// The 8 KiB output history lives in a single-port-write, single-port-read RAM.
// After reset the block zeroes every address of that RAM and holds in_stall high
// meanwhile; offset registers may be written during that time. Once running, a
// literal or control byte is taken whenever the output register is free. A
// back-reference occupies the block after its control byte until all of its bytes
// are copied: every copied byte needs a RAM read (ST_READ) followed by the RAM
// write of that byte (ST_WRITE), which waits while the output register is stalled,
// so the block copies one byte per read-then-write turn through the history RAM.
// Since each read is issued only after the previous write has landed, overlapping
// copies (short offsets) naturally repeat data like run-length coding. New source
// bytes are not accepted until the copy finishes. Offsets are taken modulo the
// window, so reads before the start of a stream return older history contents.
module lz_predictive_image_decompressor_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_wen,
    input  logic [lzpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzpid_pkg::OFS_W-1:0]      cfg_data,
    // Source channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lzpid_pkg::BYTE_W-1:0]     src_byte,
    input  logic                             src_last,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lzpid_pkg::BYTE_W-1:0]     out_byte,
    output logic                             has_byte,
    output logic                             run_last,
    output logic                             stream_end,
    output logic [lzpid_pkg::COUNT_W-1:0]    written_count
);
    import lzpid_pkg::*;

    state_t               state_reg, state_next;
    logic [RING_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [RING_AW-1:0]   wp_reg, wp_next;
    logic [RING_AW-1:0]   rd_reg, rd_next;
    logic [LEN_W-1:0]     lit_rem_reg, lit_rem_next;
    logic [LEN_W-1:0]     copy_rem_reg, copy_rem_next;
    logic                 copy_last_reg, copy_last_next;
    logic                 term_reg, term_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    offset_t              offset_reg [NUM_MODES];

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 has_byte_reg, has_byte_next;
    logic                 run_last_reg, run_last_next;
    logic                 stream_end_reg, stream_end_next;
    logic [COUNT_W-1:0]   count_out_reg, count_out_next;

    logic                 ram_we;
    logic [RING_AW-1:0]   ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [BYTE_W-1:0]    ram_rdata;

    logic                 out_free;
    logic                 in_fire;
    logic [LEN_W-1:0]     ctl_len;
    logic [MODE_W-1:0]    ctl_mode;
    logic [COUNT_W-1:0]   count_inc;
    offset_t              sel_ofs;
    logic [RING_AW+OFS_W-1:0] ofs_ext;
    logic                 copy_final;

    // The output register can take a new word when empty or when its word leaves now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_fire   = in_valid && !in_stall;

    assign ctl_len   = src_byte[BYTE_W-1:MODE_W];
    assign ctl_mode  = src_byte[MODE_W-1:0];
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Mode 1..7 selects offset register 0..6; the sign-extended offset wraps
    // modulo the window when added to the write pointer.
    assign sel_ofs    = offset_reg[ctl_mode - 1'b1];
    assign ofs_ext    = {{RING_AW{sel_ofs[OFS_W-1]}}, sel_ofs};
    assign copy_final = (copy_rem_reg == LEN_W'(1));

    lzpid_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_BYTES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_reg),
        .rd_data (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == RING_AW'(WINDOW_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && !term_reg && (lit_rem_reg == LEN_ZERO)
                    && (ctl_mode != MODE_LITERAL) && (ctl_len != LEN_ZERO))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = copy_final ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result words.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        wp_next         = wp_reg;
        rd_next         = rd_reg;
        lit_rem_next    = lit_rem_reg;
        copy_rem_next   = copy_rem_reg;
        copy_last_next  = copy_last_reg;
        term_next       = term_reg;
        count_next      = count_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        has_byte_next   = has_byte_reg;
        run_last_next   = run_last_reg;
        stream_end_next = stream_end_reg;
        count_out_next  = count_out_reg;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = src_byte;
        ram_re    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (term_reg)
                    begin
                        // Bytes after the terminator are dropped silently.
                    end
                    else if (lit_rem_reg != LEN_ZERO)
                    begin
                        ram_we          = 1'b1;
                        wp_next         = wp_reg + 1'b1;
                        count_next      = count_inc;
                        lit_rem_next    = lit_rem_reg - 1'b1;
                        out_valid_next  = 1'b1;
                        out_byte_next   = src_byte;
                        has_byte_next   = 1'b1;
                        run_last_next   = 1'b1;
                        stream_end_next = src_last;
                        count_out_next  = count_inc;
                    end
                    else if (ctl_mode == MODE_LITERAL)
                    begin
                        if (ctl_len == LEN_ZERO)
                        begin
                            term_next = 1'b1;
                        end
                        else
                        begin
                            lit_rem_next = ctl_len;
                        end
                        // Terminator, or a literal header that is also the last byte.
                        if ((ctl_len == LEN_ZERO) || src_last)
                        begin
                            out_valid_next  = 1'b1;
                            out_byte_next   = '0;
                            has_byte_next   = 1'b0;
                            run_last_next   = 1'b1;
                            stream_end_next = 1'b1;
                            count_out_next  = count_reg;
                        end
                    end
                    else if (ctl_len == LEN_ZERO)
                    begin
                        if (src_last)
                        begin
                            out_valid_next  = 1'b1;
                            out_byte_next   = '0;
                            has_byte_next   = 1'b0;
                            run_last_next   = 1'b1;
                            stream_end_next = 1'b1;
                            count_out_next  = count_reg;
                        end
                    end
                    else
                    begin
                        rd_next        = wp_reg + ofs_ext[RING_AW-1:0];
                        copy_rem_next  = ctl_len;
                        copy_last_next = src_last;
                    end

                    // Stream boundary; a back-reference defers this to its last byte.
                    if (src_last && !(state_next == ST_READ))
                    begin
                        lit_rem_next = '0;
                        term_next    = 1'b0;
                        count_next   = '0;
                    end
                end
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata;
                    wp_next         = wp_reg + 1'b1;
                    rd_next         = rd_reg + 1'b1;
                    count_next      = count_inc;
                    copy_rem_next   = copy_rem_reg - 1'b1;
                    out_valid_next  = 1'b1;
                    out_byte_next   = ram_rdata;
                    has_byte_next   = 1'b1;
                    run_last_next   = copy_final;
                    stream_end_next = copy_final && copy_last_reg;
                    count_out_next  = count_inc;
                    if (copy_final && copy_last_reg)
                    begin
                        lit_rem_next = '0;
                        term_next    = 1'b0;
                        count_next   = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            lit_rem_reg   <= '0;
            copy_rem_reg  <= '0;
            term_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MODES; i++)
            begin
                offset_reg[i] <= OFS_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wp_reg        <= wp_next;
            lit_rem_reg   <= lit_rem_next;
            copy_rem_reg  <= copy_rem_next;
            term_reg      <= term_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen && (cfg_index < CFG_IDX_W'(NUM_MODES)))
            begin
                offset_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg         <= rd_next;
        copy_last_reg  <= copy_last_next;
        out_byte_reg   <= out_byte_next;
        has_byte_reg   <= has_byte_next;
        run_last_reg   <= run_last_next;
        stream_end_reg <= stream_end_next;
        count_out_reg  <= count_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign has_byte      = has_byte_reg;
    assign run_last      = run_last_reg;
    assign stream_end    = stream_end_reg;
    assign written_count = count_out_reg;

endmodule

### design/lzpid_checker.sv
module lzpid_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [lzpid_pkg::BYTE_W-1:0]     out_byte,
    input logic                             has_byte,
    input logic                             run_last,
    input logic                             stream_end,
    input logic [lzpid_pkg::COUNT_W-1:0]    written_count
);
    import lzpid_pkg::*;

    // A bare end marker always closes both the item and the stream.
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> run_last && stream_end && (out_byte == '0))
        else $error("end marker without run_last/stream_end or with data");

    // The end of a stream is always the last word of its item.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream_end on a word that is not run_last");

    // A data word always counts itself.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> written_count != '0)
        else $error("data word with zero written count");

    // A stalled result word holds its byte, written count and run_last.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(written_count) && $stable(run_last))
        else $error("stalled result word changed");

    // A source word is only taken when the result register has room.
    a_in_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !(out_valid && out_stall))
        else $error("source word accepted while a result word is stalled");

endmodule

bind lz_predictive_image_decompressor_unit lzpid_checker u_lzpid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .has_byte      (has_byte),
    .run_last      (run_last),
    .stream_end    (stream_end),
    .written_count (written_count)
);
